// File: sv/hftd_pkg.sv
// Shared types, constants and helper functions for the humidity/temperature
// reply decoder. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hftd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [13:0] HUMID_SPAN  = 14'd10000;
    localparam logic [15:0] HUMID_MAX   = 16'd10000;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // Position of a byte within the six-byte sensor reply.
    typedef enum logic [2:0] {
        POS_T_MSB = 3'd0,
        POS_T_LSB = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_MSB = 3'd3,
        POS_H_LSB = 3'd4,
        POS_H_CRC = 3'd5
    } byte_pos_t;

    // One complete reply, handed from the front end to the conversion back end.
    typedef struct packed {
        logic        ok;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
    } frame_t;

    // CRC-8, MSB first, one byte per call.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31. Since 65535 = 2^16 - 1, the
    // remainder after taking x >> 16 is the low half plus that quotient,
    // which stays below twice the divisor, so one correction suffices.
    function automatic logic [15:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q;
        logic [16:0] r;
        logic [15:0] res;
        q   = x[30:16];
        r   = {1'b0, x[15:0]} + {2'b00, q};
        res = {1'b0, q};
        if (r >= FULL_SCALE) begin
            res = res + 16'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/hftd_front.sv
// Front end of the reply decoder: tracks the byte position, runs the CRC-8
// check and assembles the raw words. Depends on hftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hftd_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_frame_start,
    input  wire logic [7:0]      s_rx_byte,
    input  wire logic            queue_full,
    output logic                 push_valid,
    output hftd_pkg::frame_t     push_frame
);

    hftd_pkg::byte_pos_t pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] humid_word_reg, humid_word_next;
    logic        temp_pass_reg, temp_pass_next;
    logic        accept;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // A start mark, or a position that cannot occur, restarts the reply.
    always_comb begin
        pos_eff = pos_reg;
        if (s_frame_start) begin
            pos_eff = hftd_pkg::POS_T_MSB;
        end
    end

    // Next position.
    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            unique case (pos_eff)
                hftd_pkg::POS_T_MSB: pos_next = hftd_pkg::POS_T_LSB;
                hftd_pkg::POS_T_LSB: pos_next = hftd_pkg::POS_T_CRC;
                hftd_pkg::POS_T_CRC: pos_next = hftd_pkg::POS_H_MSB;
                hftd_pkg::POS_H_MSB: pos_next = hftd_pkg::POS_H_LSB;
                hftd_pkg::POS_H_LSB: pos_next = hftd_pkg::POS_H_CRC;
                hftd_pkg::POS_H_CRC: pos_next = hftd_pkg::POS_T_MSB;
                default:             pos_next = hftd_pkg::POS_T_LSB;
            endcase
        end
    end

    // Data path and outputs for the current position.
    always_comb begin
        crc_next        = crc_reg;
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;
        temp_pass_next  = temp_pass_reg;
        push_valid      = 1'b0;
        push_frame.ok        = temp_pass_reg && (crc_reg == s_rx_byte);
        push_frame.temp_raw  = temp_word_reg;
        push_frame.humid_raw = humid_word_reg;
        if (accept) begin
            unique case (pos_eff)
                hftd_pkg::POS_T_LSB: begin
                    crc_next       = hftd_pkg::crc8_feed(crc_reg, s_rx_byte);
                    temp_word_next = {temp_word_reg[15:8], s_rx_byte};
                end
                hftd_pkg::POS_T_CRC: begin
                    temp_pass_next = (crc_reg == s_rx_byte);
                end
                hftd_pkg::POS_H_MSB: begin
                    crc_next        = hftd_pkg::crc8_feed(hftd_pkg::CRC_INIT, s_rx_byte);
                    humid_word_next = {s_rx_byte, humid_word_reg[7:0]};
                end
                hftd_pkg::POS_H_LSB: begin
                    crc_next        = hftd_pkg::crc8_feed(crc_reg, s_rx_byte);
                    humid_word_next = {humid_word_reg[15:8], s_rx_byte};
                end
                hftd_pkg::POS_H_CRC: begin
                    push_valid = 1'b1;
                end
                default: begin
                    // First byte of a reply, also taken for unused position codes.
                    crc_next       = hftd_pkg::crc8_feed(hftd_pkg::CRC_INIT, s_rx_byte);
                    temp_word_next = {s_rx_byte, temp_word_reg[7:0]};
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= hftd_pkg::POS_T_MSB;
            crc_reg       <= hftd_pkg::CRC_INIT;
            temp_pass_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_pass_reg <= temp_pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_word_reg  <= temp_word_next;
        humid_word_reg <= humid_word_next;
    end

endmodule

`default_nettype wire

// File: sv/hftd_queue.sv
// Two-entry queue of complete replies between the front end and the
// conversion back end. Depends on hftd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module hftd_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    input  wire hftd_pkg::frame_t  push_frame,
    output logic                   full,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output hftd_pkg::frame_t       pop_frame
);

    hftd_pkg::frame_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_frame = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

`default_nettype wire

// File: sv/hftd_back.sv
// Conversion back end: scales the raw words into centidegrees and
// centipercent in two stages and holds the result word. Depends on hftd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hftd_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire hftd_pkg::frame_t  pop_frame,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_reading_ok,
    output logic signed [14:0]     m_temp_centideg,
    output logic [13:0]            m_humid_centipct
);

    // Stage A: the two scaling products.
    logic        a_valid_reg, a_valid_next;
    logic        a_ok_reg;
    logic [30:0] a_temp_prod_reg;
    logic [29:0] a_humid_prod_reg;

    // Output stage.
    logic        out_valid_reg, out_valid_next;
    logic        out_ok_reg;
    logic [14:0] out_temp_reg, out_temp_next;
    logic [13:0] out_humid_reg, out_humid_next;

    logic        out_load, a_load;
    logic [15:0] temp_q, humid_q, humid_clamped, temp_off;

    assign out_load  = a_valid_reg && (!out_valid_reg || m_ready);
    assign pop_ready = !a_valid_reg || out_load;
    assign a_load    = pop_valid && pop_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_load) begin
            a_valid_next = 1'b1;
        end else if (out_load) begin
            a_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        temp_q        = hftd_pkg::div_full_scale(a_temp_prod_reg);
        humid_q       = hftd_pkg::div_full_scale({1'b0, a_humid_prod_reg});
        temp_off      = temp_q - hftd_pkg::TEMP_OFFSET;
        humid_clamped = (humid_q > hftd_pkg::HUMID_MAX) ? hftd_pkg::HUMID_MAX : humid_q;
        out_temp_next  = 15'd0;
        out_humid_next = 14'd0;
        // A failed checksum reports zero for both readings.
        if (a_ok_reg) begin
            out_temp_next  = temp_off[14:0];
            out_humid_next = humid_clamped[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_ok_reg         <= pop_frame.ok;
            a_temp_prod_reg  <= 31'(pop_frame.temp_raw) * 31'(hftd_pkg::TEMP_SPAN);
            a_humid_prod_reg <= 30'(pop_frame.humid_raw) * 30'(hftd_pkg::HUMID_SPAN);
        end
        if (out_load) begin
            out_ok_reg    <= a_ok_reg;
            out_temp_reg  <= out_temp_next;
            out_humid_reg <= out_humid_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_reading_ok     = out_ok_reg;
    assign m_temp_centideg  = $signed(out_temp_reg);
    assign m_humid_centipct = out_humid_reg;

endmodule

`default_nettype wire

// File: sv/humidity_temp_frame_decoder_core.sv
// Humidity/temperature reply decoder: checks the two CRC-8 protected words of
// a six-byte sensor reply and converts them to centidegrees and centipercent.
//
// Input channel (s_): one reply byte per word, in bus order: temperature MSB,
// LSB, CRC, then humidity MSB, LSB, CRC. s_frame_start marks the first byte of
// a reply and abandons any partial one. A byte can be taken every cycle while s_ready is high.
// Result channel (m_): one word per complete reply. m_reading_ok is low when
// either CRC failed, and both readings are then zero.
// Path: the reply enters the queue at the edge that accepts the sixth byte,
// the scaling products are registered in stage A, and the division by full
// scale and the offset land in the output register, which drives m_valid.
// Throughput: one byte per cycle sustained while s_ready is high; a reply is six bytes.
// When the receiver stalls, the output register, the product stage and a
// two-entry reply queue fill in turn; only then is s_ready dropped.
// Reset (aresetn low, synchronous) empties the queue and pipeline and returns
// to the start of a reply with the CRC preset to all ones.
// Depends on hftd_pkg, hftd_front, hftd_queue and hftd_back.
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_decoder_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_frame_start,
    input  wire logic [7:0]   s_rx_byte,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_reading_ok,
    output logic signed [14:0] m_temp_centideg,
    output logic [13:0]       m_humid_centipct
);

    logic             queue_full;
    logic             push_valid;
    hftd_pkg::frame_t push_frame;
    logic             pop_valid;
    logic             pop_ready;
    hftd_pkg::frame_t pop_frame;

    hftd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_start (s_frame_start),
        .s_rx_byte     (s_rx_byte),
        .queue_full    (queue_full),
        .push_valid    (push_valid),
        .push_frame    (push_frame)
    );

    hftd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_frame (push_frame),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    hftd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_frame        (pop_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_reading_ok     (m_reading_ok),
        .m_temp_centideg  (m_temp_centideg),
        .m_humid_centipct (m_humid_centipct)
    );

endmodule

`default_nettype wire
